// ----- sv/ins_pkg.sv -----
// Package: shared constants and transfer types for the insertion sorter.
`default_nettype none
package ins_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_of_run;
    logic               overflow;
  } out_item_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

endpackage
`default_nettype wire

// ----- sv/ins_cell.sv -----
// Module: one compare-and-shift cell of the sorting row.
`default_nettype none
module ins_cell (
  input  wire logic               clk,
  input  wire ins_pkg::cell_ctl_t ctl,
  input  wire logic signed [31:0] new_value,
  input  wire logic               occ,
  input  wire logic               lower_gt,
  input  wire logic signed [31:0] lower_value,
  input  wire logic signed [31:0] upper_value,
  output logic signed [31:0]      value,
  output logic                    gt
);
  import ins_pkg::*;

  logic signed [31:0] value_r;
  logic signed [31:0] value_nxt;

  // An empty cell counts as larger than anything.
  assign gt    = !occ || (value_r > new_value);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    if (ctl.shift) begin
      value_nxt = upper_value;
    end else if (ctl.insert && gt) begin
      value_nxt = lower_gt ? lower_value : new_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
`default_nettype wire

// ----- sv/insertion_sorter.sv -----
// Module: streaming insertion sorter built from a row of compare-and-shift cells.
//
//  channel  | ports                    | transfer
//  ---------+--------------------------+------------------------------------------
//  input    | start, busy, in_item     | edge with start high and busy low
//  result   | out_valid, out_item      | edge ending each cycle out_valid is high
//
// Flow: a value without the last mark is inserted and the next one may follow
// every cycle. A value with the last mark is inserted the same way, then the row
// shifts down one place a cycle toward cell 0, giving n results (n = entries
// held, 1..CAPACITY) on consecutive cycles; busy is high while the row shifts,
// and each result is registered from cell 0. Reset is synchronous, clears the
// state, count, drop flag and strobe. The receiver cannot stall: each result stands for exactly one cycle.
`default_nettype none
module insertion_sorter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire ins_pkg::in_item_t in_item,
  output logic                   out_valid,
  output ins_pkg::out_item_t     out_item
);
  import ins_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  cell_ctl_t                  ctl;
  logic                       accept;
  logic                       full;
  logic [CAPACITY-1:0]        occ;
  logic [CAPACITY-1:0]        gt;
  logic signed [31:0]         cell_value [CAPACITY];

  assign busy      = (state_r == ST_EMIT);
  assign accept    = start && !busy;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Drop the value when the row is full; shift down while emitting.
  assign ctl.insert = accept && !full;
  assign ctl.shift  = busy;

  // Thermometer occupancy of the row from the fill count.
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_row
      logic               lower_gt;
      logic signed [31:0] lower_value;
      logic signed [31:0] upper_value;

      assign occ[i] = (CNT_W'(i) < count_r);

      if (i == 0) begin : g_first
        assign lower_gt    = 1'b0;
        assign lower_value = '0;
      end else begin : g_inner
        assign lower_gt    = gt[i-1];
        assign lower_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign upper_value = cell_value[i];
      end else begin : g_below
        assign upper_value = cell_value[i+1];
      end

      ins_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .new_value   (in_item.value),
        .occ         (occ[i]),
        .lower_gt    (lower_gt),
        .lower_value (lower_value),
        .upper_value (upper_value),
        .value       (cell_value[i]),
        .gt          (gt[i])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_item.last_item) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // Cell 0 holds the smallest remaining entry; hand it out and advance.
        out_valid_nxt             = 1'b1;
        out_item_nxt.sorted_value = cell_value[0];
        out_item_nxt.last_of_run  = (count_r == CNT_W'(1));
        out_item_nxt.overflow     = dropped_r;
        count_nxt                 = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          state_nxt   = ST_LOAD;
          dropped_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule
`default_nettype wire

// ----- sv/ins_checker.sv -----
// Checker: port-level temporal checks on the insertion sorter, with its bind.
`default_nettype none
module ins_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire ins_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire ins_pkg::out_item_t out_item
);
  import ins_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("busy or strobe set after reset");

  a_last_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.last_item |=> busy)
    else $error("last item did not start the emit phase");

  a_out_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an emit cycle before it");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_of_run |=> !out_valid)
    else $error("result after the final one of a run");

  a_run_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_of_run |=> out_valid && $stable(out_item.overflow))
    else $error("run broken or overflow changed within a run");

endmodule

bind insertion_sorter ins_checker u_ins_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire
